// ===== rtl/core/sfpp_pkg.sv =====
`timescale 1ns / 1ps

package sfpp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 1'b1;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h75;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h65;

   typedef enum logic [6:0] {
      PH_HUNT0 = 7'b0000001,
      PH_HUNT1 = 7'b0000010,
      PH_SET   = 7'b0000100,
      PH_LEN   = 7'b0001000,
      PH_PAY   = 7'b0010000,
      PH_CHK0  = 7'b0100000,
      PH_CHK1  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_payload;
      logic [BYTE_W-1:0] payload_index;
      logic              packet_done;
      logic              checksum_ok;
      logic [BYTE_W-1:0] descriptor_set;
      logic [BYTE_W-1:0] payload_length;
   } rsp_type;

endpackage

// ===== rtl/core/sfpp_parse.sv =====
`timescale 1ns / 1ps

module sfpp_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [sfpp_pkg::BYTE_W-1:0] sync_first,
   input  logic [sfpp_pkg::BYTE_W-1:0] sync_second,
   input  logic                        take,
   input  logic [sfpp_pkg::BYTE_W-1:0] rx_byte,
   output sfpp_pkg::rsp_type           result
);
   import sfpp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] descriptor_ff, descriptor_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] check_high_ff, check_high_in;
   logic [BYTE_W-1:0] acc_a, acc_b, count_inc;

   assign acc_a     = sum_a_ff + rx_byte;
   assign acc_b     = sum_b_ff + acc_a;
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      descriptor_in = descriptor_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      check_high_in = check_high_ff;
      result        = '0;
      result.out_byte = rx_byte;

      case (phase_ff)
         PH_HUNT1: begin
            if (rx_byte == sync_second) begin
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               phase_in = PH_SET;
            end else begin
               // drop back; the missed byte is not retried as a first sync
               phase_in = PH_HUNT0;
            end
         end
         PH_SET: begin
            descriptor_in = rx_byte;
            sum_a_in      = acc_a;
            sum_b_in      = acc_b;
            phase_in      = PH_LEN;
         end
         PH_LEN: begin
            length_in = rx_byte;
            count_in  = '0;
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
            phase_in  = (rx_byte == '0) ? PH_CHK0 : PH_PAY;
         end
         PH_PAY: begin
            result.is_payload    = 1'b1;
            result.payload_index = count_ff;
            sum_a_in = acc_a;
            sum_b_in = acc_b;
            count_in = count_inc;
            if (count_inc >= length_ff) begin
               phase_in = PH_CHK0;
            end
         end
         PH_CHK0: begin
            check_high_in = rx_byte;
            phase_in      = PH_CHK1;
         end
         PH_CHK1: begin
            result.packet_done = 1'b1;
            result.checksum_ok = (check_high_ff == sum_a_ff) && (rx_byte == sum_b_ff);
            phase_in = PH_HUNT0;
         end
         default: begin
            // hunting for the first sync byte
            if (rx_byte == sync_first) begin
               descriptor_in = '0;
               length_in     = '0;
               count_in      = '0;
               check_high_in = '0;
               sum_a_in      = rx_byte;
               sum_b_in      = rx_byte;
               phase_in      = PH_HUNT1;
            end else begin
               phase_in = PH_HUNT0;
            end
         end
      endcase

      result.descriptor_set = descriptor_in;
      result.payload_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT0;
         descriptor_ff <= '0;
         length_ff     <= '0;
         count_ff      <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         check_high_ff <= '0;
      end else if (take) begin
         phase_ff      <= phase_in;
         descriptor_ff <= descriptor_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         check_high_ff <= check_high_in;
      end
   end

`ifndef SYNTH
   a_chk1_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (take && phase_ff == PH_CHK1) |=> (phase_ff == PH_HUNT0))
      else $error("phase did not return to hunting after the checksum");

   a_pay_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (count_ff < length_ff))
      else $error("payload count reached the held length inside the payload");

   a_pay_nonzero_length: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (length_ff != '0))
      else $error("payload phase entered with a zero length");
`endif

endmodule

// ===== rtl/core/sfpp_out_reg.sv =====
`timescale 1ns / 1ps

module sfpp_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  sfpp_pkg::rsp_type result,
   input  logic              out_stall,
   output logic              out_valid,
   output sfpp_pkg::rsp_type out_data
);
   import sfpp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // hold while the beat waits on a stall, otherwise take whatever arrives
   assign valid_in = (valid_ff && out_stall) ? 1'b1 : load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/sync_framed_packet_parser_fletcher.sv =====
`timescale 1ns / 1ps
// An accepted byte's result is registered in the output register and shows on rsp_.
// Throughput: one byte per cycle while req_stall is low; the phase, length count and
// running sums update in one pass from the input byte into the result register.
// req_stall rises only while a result sits in the output register under rsp_stall.
// Reset (synchronous, active high) returns to hunting, clears held fields and sums,
// and restores the sync bytes to 0x75 and 0x65.

module sync_framed_packet_parser_fletcher (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [sfpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfpp_pkg::BYTE_W-1:0]      csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sfpp_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sfpp_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_is_payload,
   output logic [sfpp_pkg::BYTE_W-1:0]      rsp_payload_index,
   output logic                             rsp_packet_done,
   output logic                             rsp_checksum_ok,
   output logic [sfpp_pkg::BYTE_W-1:0]      rsp_descriptor_set,
   output logic [sfpp_pkg::BYTE_W-1:0]      rsp_payload_length
);
   import sfpp_pkg::*;

   logic [BYTE_W-1:0] sync_first_ff, sync_second_ff;
   logic              take;
   rsp_type           result, out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_write_data;
            CSR_SYNC_SECOND: sync_second_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = rsp_valid && rsp_stall;
   assign take      = req_valid && !req_stall;

   sfpp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .take        (take),
      .rx_byte     (req_rx_byte),
      .result      (result)
   );

   sfpp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .result    (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_out_byte       = out_data.out_byte;
   assign rsp_is_payload     = out_data.is_payload;
   assign rsp_payload_index  = out_data.payload_index;
   assign rsp_packet_done    = out_data.packet_done;
   assign rsp_checksum_ok    = out_data.checksum_ok;
   assign rsp_descriptor_set = out_data.descriptor_set;
   assign rsp_payload_length = out_data.payload_length;

`ifndef SYNTH
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted byte produced no result beat");

   a_result_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_payload && rsp_packet_done))
      else $error("result marked both payload and packet end");

   a_stalled_beat_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(out_data)))
      else $error("stalled result beat changed or dropped");
`endif

endmodule
